FILE: design/vdt_pkg.sv
// Package for the vertex dedup table: table sizing, command codes, beat types
// and the controller-to-datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vdt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = 16;
    localparam int TOL_W       = 8;
    localparam int INDEX_W     = 8;
    localparam int TOTAL_W     = 9;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_MERGE   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 command;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic                       last_of_face;
    } item_beat_t;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               was_new;
        logic               table_full;
        logic               face_end;
        logic [TOTAL_W-1:0] entry_total;
    } result_beat_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic scan;
        logic append;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: design/vdt_ctrl.sv
// Controller for the vertex dedup table: sequences accept, scan, append and
// result hand-off. Depends on vdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vdt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire logic [1:0]        command,
    input  wire vdt_pkg::dp_status_t status,
    output vdt_pkg::dp_cmd_t       cmd
);
    import vdt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_RESP;
                        end
                        CMD_PRELOAD: state_next = ST_APPEND;
                        CMD_MERGE:   state_next = ST_SCAN;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit)
                begin
                    state_next = ST_RESP;
                end
                else if (status.exhausted)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/vdt_datapath.sv
// Datapath for the vertex dedup table: vertex memory, entry count, tolerance
// register, scan pipeline with comparators and the result register.
// Depends on vdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vdt_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vdt_pkg::item_beat_t   item,
    input  wire logic                  cfg_valid,
    input  wire logic [vdt_pkg::TOL_W-1:0] cfg_data,
    input  wire vdt_pkg::dp_cmd_t      cmd,
    output vdt_pkg::dp_status_t        status,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output vdt_pkg::result_beat_t      result
);
    import vdt_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    vertex_t            mem [TABLE_DEPTH];

    item_beat_t         item_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_addr_reg;
    logic               rd_valid_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;
    vertex_t            rd_data_reg;
    logic [ADDR_W-1:0]  res_idx_reg;
    logic               res_new_reg;
    logic               res_full_reg;
    logic               result_valid_reg;
    result_beat_t       result_reg;

    logic               issue;
    logic               hit;
    logic               has_room;
    logic [31:0]        idx_wide;
    logic [31:0]        total_wide;

    function automatic logic near(input logic signed [COORD_W-1:0] a,
                                  input logic signed [COORD_W-1:0] b,
                                  input logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag;
        diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        mag  = diff[COORD_W] ? (COORD_W + 1)'(0) - diff : diff;
        return mag <= {{(COORD_W + 1 - TOL_W){1'b0}}, tol};
    endfunction

    assign has_room = count_reg < CNT_W'(TABLE_DEPTH);
    assign hit      = rd_valid_reg
                    && near(item_reg.coord_x, rd_data_reg.x, tol_reg)
                    && near(item_reg.coord_y, rd_data_reg.y, tol_reg)
                    && near(item_reg.coord_z, rd_data_reg.z, tol_reg);
    assign issue    = cmd.scan && !hit && (scan_addr_reg < count_reg);

    assign status.hit       = hit;
    assign status.exhausted = (scan_addr_reg == count_reg) && !rd_valid_reg;
    assign status.out_free  = !result_valid_reg || result_ready;

    assign idx_wide   = 32'(res_idx_reg);
    assign total_wide = 32'(count_reg);

    // vertex memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append && has_room)
        begin
            mem[count_reg[ADDR_W-1:0]] <= '{x: item_reg.coord_x,
                                           y: item_reg.coord_y,
                                           z: item_reg.coord_z};
        end
        rd_data_reg <= mem[scan_addr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (issue)
        begin
            rd_idx_reg <= scan_addr_reg[ADDR_W-1:0];
        end
        if (cmd.emit)
        begin
            result_reg.vertex_index <= idx_wide[INDEX_W-1:0];
            result_reg.was_new      <= res_new_reg;
            result_reg.table_full   <= res_full_reg;
            result_reg.face_end     <= item_reg.last_of_face;
            result_reg.entry_total  <= total_wide[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg          <= '0;
            count_reg        <= '0;
            scan_addr_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            res_idx_reg      <= '0;
            res_new_reg      <= 1'b0;
            res_full_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end

            if (cmd.accept)
            begin
                scan_addr_reg <= '0;
                rd_valid_reg  <= 1'b0;
                res_idx_reg   <= '0;
                res_new_reg   <= 1'b0;
                res_full_reg  <= 1'b0;
                if (cmd.clear)
                begin
                    count_reg <= '0;
                end
            end
            else
            begin
                rd_valid_reg <= issue;
                if (issue)
                begin
                    scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                end
            end

            // hold the first matching index
            if (cmd.scan && hit)
            begin
                res_idx_reg <= rd_idx_reg;
            end

            if (cmd.append)
            begin
                if (has_room)
                begin
                    res_idx_reg <= count_reg[ADDR_W-1:0];
                    res_new_reg <= 1'b1;
                    count_reg   <= count_reg + CNT_W'(1);
                end
                else
                begin
                    res_full_reg <= 1'b1;
                end
            end

            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: design/vertex_dedup_table.sv
// Vertex dedup table: one result beat per item beat. A clear or an unused command
// goes from accept straight to loading the result register; a preload first
// appends the item. A merge scans the stored entries in order through the single
// registered memory read port, one entry per cycle, and stops at the first entry
// that matches, or appends the item when no stored entry matches.
// The next item can be accepted in the cycle after the result register loads,
// and a beat still held in the output register delays that load. Items are taken
// one at a time; the next item is accepted while a result beat still waits in
// the output register. A tolerance write takes effect the next cycle, so write
// it only while no item is in flight. Depends on vdt_pkg, vdt_ctrl, vdt_datapath.
`timescale 1ns / 1ps
`default_nettype none

module vertex_dedup_table (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire vdt_pkg::item_beat_t    item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [vdt_pkg::TOL_W-1:0] cfg_data,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output vdt_pkg::result_beat_t       result
);
    import vdt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    vdt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (item.command),
        .status     (status),
        .cmd        (cmd)
    );

    vdt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
